FILE: hw/rtl/complex_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// Complex arithmetic unit: assertion macros
// Shared property shorthands; clock clk, synchronous active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Types, widths and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WIDTH            = 16;
  localparam int FRAC_BITS        = 12;
  localparam int CMD_W            = 3;
  localparam int ST_W             = 2;
  localparam int GUARD_BITS       = 12;
  localparam int ANG_BITS         = 30;
  localparam int DEF_CORDIC_STEPS = 16;

  localparam int SUM_W  = WIDTH + 1;
  localparam int PROD_W = 2 * WIDTH;
  localparam int MUL_W  = 2 * WIDTH + 1;
  localparam int PRE_W  = WIDTH + 8;
  localparam int QBITS  = WIDTH + 1;
  localparam int DEN_W  = 2 * WIDTH;
  localparam int REM_W  = DEN_W + QBITS;
  localparam int CX_W   = WIDTH + GUARD_BITS + 4;
  localparam int Z_W    = ANG_BITS + 5;
  localparam int GAIN_W = 30;
  localparam int MAGP_W = CX_W + GAIN_W;
  localparam int MAG_SH = ANG_BITS + GUARD_BITS;
  localparam int ANG_SH = ANG_BITS - FRAC_BITS;

  localparam logic [GAIN_W-1:0]    INV_GAIN = 30'd652032874;
  localparam logic signed [Z_W-1:0] PI_Q30  = 35'sd3373259426;

  localparam logic signed [WIDTH-1:0] RES_MAX = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic signed [WIDTH-1:0] RES_MIN = {1'b1, {(WIDTH-1){1'b0}}};

  localparam logic signed [Z_W-1:0] ATAN_TAB [10] = '{
    35'sh03243F6A8, 35'sh01DAC6705, 35'sh00FADBAFC, 35'sh007F56EA6, 35'sh003FEAB76,
    35'sh001FFD55B, 35'sh000FFFAAA, 35'sh0007FFF55, 35'sh0003FFFEA, 35'sh0001FFFFD
  };

  typedef enum logic [CMD_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4,
    OP_ARG = 3'd5
  } cau_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } cau_status_t;

  // after the multiplier stage
  typedef struct packed {
    cau_op_t                  op;
    logic signed [WIDTH-1:0]  ar;
    logic signed [WIDTH-1:0]  ai;
    logic signed [SUM_W-1:0]  lin_re;
    logic signed [SUM_W-1:0]  lin_im;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic signed [PROD_W-1:0] p_ir;
    logic signed [PROD_W-1:0] p_bb_r;
    logic signed [PROD_W-1:0] p_bb_i;
  } cau_prod_t;

  // word carried along the cell chain
  typedef struct packed {
    cau_op_t                 op;
    logic signed [PRE_W-1:0] lin_re;
    logic signed [PRE_W-1:0] lin_im;
    logic                    dz;
    logic                    neg_re;
    logic                    neg_im;
    logic                    ovf_re;
    logic                    ovf_im;
    logic [DEN_W-1:0]        den;
    logic [REM_W-1:0]        rem_re;
    logic [REM_W-1:0]        rem_im;
    logic [QBITS-1:0]        q_re;
    logic [QBITS-1:0]        q_im;
    logic                    zero;
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cau_pipe_t;

  // after the gain multiplier
  typedef struct packed {
    cau_op_t                 op;
    logic signed [PRE_W-1:0] lin_re;
    logic signed [PRE_W-1:0] lin_im;
    logic                    dz;
    logic                    zero;
    logic signed [PRE_W-1:0] div_re;
    logic signed [PRE_W-1:0] div_im;
    logic [MAGP_W-1:0]       magp;
    logic signed [PRE_W-1:0] ang;
  } cau_fin_t;

  typedef struct packed {
    logic                    flag;
    logic signed [WIDTH-1:0] val;
  } cau_sat_t;

  function automatic cau_sat_t sat_w(input logic signed [PRE_W-1:0] v);
    logic signed [PRE_W-1:0] hi;
    logic signed [PRE_W-1:0] lo;
    cau_sat_t                r;
    hi = {{(PRE_W-WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};
    lo = ~hi;
    r.flag = 1'b0;
    r.val  = v[WIDTH-1:0];
    if (v > hi) begin
      r.flag = 1'b1;
      r.val  = RES_MAX;
    end else if (v < lo) begin
      r.flag = 1'b1;
      r.val  = RES_MIN;
    end
    return r;
  endfunction

  // rotation angle of CORDIC step i, Q30
  function automatic logic signed [Z_W-1:0] angle_step(input int i);
    logic signed [Z_W-1:0] r;
    if (i < 10) begin
      r = ATAN_TAB[i[3:0]];
    end else if (i <= ANG_BITS) begin
      r = {{(Z_W-1){1'b0}}, 1'b1} << (ANG_BITS - i);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Operand multipliers, then sums, divider set-up and CORDIC pre-rotation.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [WIDTH-1:0] in_a_re,
  input  logic signed [WIDTH-1:0] in_a_im,
  input  logic signed [WIDTH-1:0] in_b_re,
  input  logic signed [WIDTH-1:0] in_b_im,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output cau_pipe_t               dn_data
);

  localparam logic signed [MUL_W-1:0] MUL_RND = MUL_W'(1) <<< (FRAC_BITS - 1);

  logic      a_v_r, b_v_r;
  logic      a_adv, b_adv;
  cau_prod_t a_r, a_nxt;
  cau_pipe_t b_r, b_nxt;

  logic signed [MUL_W-1:0]           mul_re, mul_im, num_re, num_im;
  logic signed [MUL_W-FRAC_BITS-1:0] mul_re_sh, mul_im_sh;
  logic [MUL_W-1:0]                  mag_re, mag_im;
  logic [DEN_W-1:0]                  den;
  logic [REM_W-1:0]                  den_top;
  logic signed [CX_W-1:0]            x0, y0;

  assign a_adv    = !a_v_r || b_adv;
  assign b_adv    = !b_v_r || dn_ready;
  assign in_ready = a_adv;

  always_comb begin
    a_nxt        = '0;
    a_nxt.op     = cau_op_t'(in_cmd);
    a_nxt.ar     = in_a_re;
    a_nxt.ai     = in_a_im;
    if (cau_op_t'(in_cmd) == OP_SUB) begin
      a_nxt.lin_re = SUM_W'(in_a_re) - SUM_W'(in_b_re);
      a_nxt.lin_im = SUM_W'(in_a_im) - SUM_W'(in_b_im);
    end else begin
      a_nxt.lin_re = SUM_W'(in_a_re) + SUM_W'(in_b_re);
      a_nxt.lin_im = SUM_W'(in_a_im) + SUM_W'(in_b_im);
    end
    a_nxt.p_rr   = in_a_re * in_b_re;
    a_nxt.p_ii   = in_a_im * in_b_im;
    a_nxt.p_ri   = in_a_re * in_b_im;
    a_nxt.p_ir   = in_a_im * in_b_re;
    a_nxt.p_bb_r = in_b_re * in_b_re;
    a_nxt.p_bb_i = in_b_im * in_b_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_adv) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_r <= a_nxt;
    end
  end

  always_comb begin
    mul_re    = MUL_W'(a_r.p_rr) - MUL_W'(a_r.p_ii) + MUL_RND;
    mul_im    = MUL_W'(a_r.p_ri) + MUL_W'(a_r.p_ir) + MUL_RND;
    mul_re_sh = mul_re[MUL_W-1:FRAC_BITS];
    mul_im_sh = mul_im[MUL_W-1:FRAC_BITS];
    num_re    = MUL_W'(a_r.p_rr) + MUL_W'(a_r.p_ii);
    num_im    = MUL_W'(a_r.p_ir) - MUL_W'(a_r.p_ri);
    mag_re    = num_re[MUL_W-1] ? $unsigned(-num_re) : $unsigned(num_re);
    mag_im    = num_im[MUL_W-1] ? $unsigned(-num_im) : $unsigned(num_im);
    den       = $unsigned(a_r.p_bb_r) + $unsigned(a_r.p_bb_i);
    den_top   = {den, {QBITS{1'b0}}};
    x0        = CX_W'(a_r.ar) <<< GUARD_BITS;
    y0        = CX_W'(a_r.ai) <<< GUARD_BITS;

    b_nxt        = '0;
    b_nxt.op     = a_r.op;
    if (a_r.op == OP_MUL) begin
      b_nxt.lin_re = PRE_W'(mul_re_sh);
      b_nxt.lin_im = PRE_W'(mul_im_sh);
    end else begin
      b_nxt.lin_re = PRE_W'(a_r.lin_re);
      b_nxt.lin_im = PRE_W'(a_r.lin_im);
    end
    b_nxt.dz     = (den == '0);
    b_nxt.neg_re = num_re[MUL_W-1];
    b_nxt.neg_im = num_im[MUL_W-1];
    b_nxt.den    = den;
    // dividend = |num| scaled by 2^FRAC_BITS plus half the divisor
    b_nxt.rem_re = REM_W'({mag_re[DEN_W-1:0], {FRAC_BITS{1'b0}}}) + REM_W'(den >> 1);
    b_nxt.rem_im = REM_W'({mag_im[DEN_W-1:0], {FRAC_BITS{1'b0}}}) + REM_W'(den >> 1);
    b_nxt.ovf_re = (b_nxt.rem_re >= den_top);
    b_nxt.ovf_im = (b_nxt.rem_im >= den_top);
    b_nxt.zero   = (a_r.ar == '0) && (a_r.ai == '0);
    // left half-plane: turn by pi first
    if (a_r.ar[WIDTH-1]) begin
      b_nxt.x = -x0;
      b_nxt.y = -y0;
      b_nxt.z = a_r.ai[WIDTH-1] ? -PI_Q30 : PI_Q30;
    end else begin
      b_nxt.x = x0;
      b_nxt.y = y0;
      b_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_v_r) begin
      b_r <= b_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_data  = b_r;

endmodule

FILE: hw/rtl/cau_cell.sv
// ----------------------------------------------------------------------------
// cau_cell
// One chain cell: a CORDIC vectoring step and/or one restoring quotient bit.
// ----------------------------------------------------------------------------
module cau_cell import cau_pkg::*; #(
  parameter int IDX          = 0,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  cau_pipe_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output cau_pipe_t dn_data
);

  logic      v_r, adv;
  cau_pipe_t d_r, d_nxt;

  logic signed [CX_W-1:0] rot_x, rot_y;
  logic signed [Z_W-1:0]  rot_z;
  logic [REM_W-1:0]       div_rem_re, div_rem_im;
  logic [QBITS-1:0]       div_q_re, div_q_im;

  generate
    if (IDX < CORDIC_STEPS) begin : g_rot
      localparam logic signed [Z_W-1:0] ANG = angle_step(IDX);
      logic signed [CX_W-1:0] dx, dy;
      always_comb begin
        dx = up_data.y >>> IDX;
        dy = up_data.x >>> IDX;
        if (up_data.y[CX_W-1]) begin
          rot_x = up_data.x - dx;
          rot_y = up_data.y + dy;
          rot_z = up_data.z - ANG;
        end else begin
          rot_x = up_data.x + dx;
          rot_y = up_data.y - dy;
          rot_z = up_data.z + ANG;
        end
      end
    end else begin : g_rot_pass
      assign rot_x = up_data.x;
      assign rot_y = up_data.y;
      assign rot_z = up_data.z;
    end

    if (IDX < QBITS) begin : g_div
      localparam int QK = QBITS - 1 - IDX;
      logic [REM_W-1:0] t;
      always_comb begin
        t          = REM_W'(up_data.den) << QK;
        div_rem_re = up_data.rem_re;
        div_rem_im = up_data.rem_im;
        div_q_re   = up_data.q_re;
        div_q_im   = up_data.q_im;
        if (up_data.rem_re >= t) begin
          div_rem_re   = up_data.rem_re - t;
          div_q_re[QK] = 1'b1;
        end
        if (up_data.rem_im >= t) begin
          div_rem_im   = up_data.rem_im - t;
          div_q_im[QK] = 1'b1;
        end
      end
    end else begin : g_div_pass
      assign div_rem_re = up_data.rem_re;
      assign div_rem_im = up_data.rem_im;
      assign div_q_re   = up_data.q_re;
      assign div_q_im   = up_data.q_im;
    end
  endgenerate

  always_comb begin
    d_nxt        = up_data;
    d_nxt.x      = rot_x;
    d_nxt.y      = rot_y;
    d_nxt.z      = rot_z;
    d_nxt.rem_re = div_rem_re;
    d_nxt.rem_im = div_rem_im;
    d_nxt.q_re   = div_q_re;
    d_nxt.q_im   = div_q_im;
  end

  assign adv      = !v_r || dn_ready;
  assign up_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

FILE: hw/rtl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Gain multiply and angle rounding, then result select, saturation, status.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  cau_pipe_t               up_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [WIDTH-1:0] out_res_re,
  output logic signed [WIDTH-1:0] out_res_im,
  output logic [ST_W-1:0]         out_status
);

  localparam logic signed [PRE_W-1:0] DIV_BIG = PRE_W'(1) <<< (PRE_W - 2);
  localparam logic signed [Z_W-1:0]   ANG_RND = Z_W'(1) <<< (ANG_SH - 1);
  localparam logic [MAGP_W-1:0]       MAG_RND = MAGP_W'(1) << (MAG_SH - 1);

  logic     c_v_r, c_adv, o_v_r, o_adv;
  cau_fin_t c_r, c_nxt;

  logic signed [Z_W-1:0]        z_rnd;
  logic signed [Z_W-ANG_SH-1:0] ang_sh;
  logic signed [PRE_W-1:0]      q_re_s, q_im_s;
  logic [MAGP_W-1:0]            mag_rnd;
  logic [MAGP_W-MAG_SH-1:0]     mag_sh;
  logic signed [PRE_W-1:0]      pre_re, pre_im;
  cau_sat_t                     s_re, s_im;
  cau_status_t                  st_nxt, st_r;
  logic signed [WIDTH-1:0]      re_r, im_r;

  assign o_adv    = !o_v_r || out_ready;
  assign c_adv    = !c_v_r || o_adv;
  assign up_ready = c_adv;

  always_comb begin
    z_rnd  = up_data.z + ANG_RND;
    ang_sh = z_rnd[Z_W-1:ANG_SH];
    q_re_s = PRE_W'(up_data.q_re);
    q_im_s = PRE_W'(up_data.q_im);

    c_nxt        = '0;
    c_nxt.op     = up_data.op;
    c_nxt.lin_re = up_data.lin_re;
    c_nxt.lin_im = up_data.lin_im;
    c_nxt.dz     = up_data.dz;
    c_nxt.zero   = up_data.zero;
    // quotient too large for QBITS: push well past the clamp
    if (up_data.ovf_re) begin
      c_nxt.div_re = up_data.neg_re ? -DIV_BIG : DIV_BIG;
    end else begin
      c_nxt.div_re = up_data.neg_re ? -q_re_s : q_re_s;
    end
    if (up_data.ovf_im) begin
      c_nxt.div_im = up_data.neg_im ? -DIV_BIG : DIV_BIG;
    end else begin
      c_nxt.div_im = up_data.neg_im ? -q_im_s : q_im_s;
    end
    c_nxt.magp = $unsigned(up_data.x) * INV_GAIN;
    c_nxt.ang  = PRE_W'(ang_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_adv) begin
      c_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv && up_valid) begin
      c_r <= c_nxt;
    end
  end

  always_comb begin
    mag_rnd = c_r.magp + MAG_RND;
    mag_sh  = mag_rnd[MAGP_W-1:MAG_SH];
    pre_re  = '0;
    pre_im  = '0;
    unique case (c_r.op)
      OP_ADD, OP_SUB, OP_MUL: begin
        pre_re = c_r.lin_re;
        pre_im = c_r.lin_im;
      end
      OP_DIV: begin
        if (!c_r.dz) begin
          pre_re = c_r.div_re;
          pre_im = c_r.div_im;
        end
      end
      OP_MAG: begin
        if (!c_r.zero) begin
          pre_re = PRE_W'(mag_sh);
        end
      end
      OP_ARG: begin
        if (!c_r.zero) begin
          pre_re = c_r.ang;
        end
      end
      default: begin
        pre_re = '0;
        pre_im = '0;
      end
    endcase
    s_re = sat_w(pre_re);
    s_im = sat_w(pre_im);
    if (c_r.op == OP_DIV && c_r.dz) begin
      st_nxt = ST_DZ;
    end else if (s_re.flag || s_im.flag) begin
      st_nxt = ST_SAT;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_adv) begin
      o_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && c_v_r) begin
      re_r <= s_re.val;
      im_r <= s_im.val;
      st_r <= st_nxt;
    end
  end

  assign out_valid  = o_v_r;
  assign out_res_re = re_r;
  assign out_res_im = im_r;
  assign out_status = st_r;

endmodule

FILE: hw/rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply and divide two complex
// Q4.12 words, or give the magnitude or argument (radians) of the first one
// by CORDIC vectoring. Fully pipelined: one word is accepted every cycle
// until back-pressure fills every stage. The pipeline is a chain of cells,
// each doing one CORDIC rotation, one quotient bit of the divider or both,
// plus two front stages (multipliers, set-up) and two back stages (gain
// multiply, saturation). Every stage holds its word under back-pressure and
// bubbles close up, so input is still taken while a finished result waits,
// as long as some stage is free.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Top level: front end, chain of CORDIC/divider cells, back end.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [WIDTH-1:0] in_a_re,
  input  logic signed [WIDTH-1:0] in_a_im,
  input  logic signed [WIDTH-1:0] in_b_re,
  input  logic signed [WIDTH-1:0] in_b_im,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [WIDTH-1:0] out_res_re,
  output logic signed [WIDTH-1:0] out_res_im,
  output logic [ST_W-1:0]         out_status
);

  localparam int NCELLS = (CORDIC_STEPS > QBITS) ? CORDIC_STEPS : QBITS;

  logic      ch_v   [NCELLS+1];
  logic      ch_rdy [NCELLS+1];
  cau_pipe_t ch_d   [NCELLS+1];

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .in_a_re  (in_a_re),
    .in_a_im  (in_a_im),
    .in_b_re  (in_b_re),
    .in_b_im  (in_b_im),
    .dn_valid (ch_v[0]),
    .dn_ready (ch_rdy[0]),
    .dn_data  (ch_d[0])
  );

  generate
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
      cau_cell #(
        .IDX          (g),
        .CORDIC_STEPS (CORDIC_STEPS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ch_v[g]),
        .up_ready (ch_rdy[g]),
        .up_data  (ch_d[g]),
        .dn_valid (ch_v[g+1]),
        .dn_ready (ch_rdy[g+1]),
        .dn_data  (ch_d[g+1])
      );
    end
  endgenerate

  cau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (ch_v[NCELLS]),
    .up_ready   (ch_rdy[NCELLS]),
    .up_data    (ch_d[NCELLS]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res_re (out_res_re),
    .out_res_im (out_res_im),
    .out_status (out_status)
  );

  // input only stalls once every stage is full behind a waiting result
  `CAU_ASSERT_IMP(a_stall_full, !in_ready, out_valid && !out_ready, "input stalled with room")
  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_status == ST_DZ, out_res_re == '0 && out_res_im == '0, "div by zero result not zero")
  `CAU_ASSERT_IMP(a_sat_clamped, out_valid && out_status == ST_SAT, out_res_re == RES_MAX || out_res_re == RES_MIN || out_res_im == RES_MAX || out_res_im == RES_MIN, "saturated without clamp")
  `CAU_ASSERT_NXT(a_chain_hold, ch_v[NCELLS] && !ch_rdy[NCELLS], ch_v[NCELLS] && $stable(ch_d[NCELLS]), "chain word lost under stall")

endmodule
